// File: sv/trcw_pkg.sv
// ----------------------------------------------------------------------------
// trcw_pkg
// Shared types, constants and the microcode program of the congestion
// window tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package trcw_pkg;

    // field and port widths
    localparam int WORD_W      = 32;
    localparam int SEG_W       = 16;
    localparam int CMD_W       = 3;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 128;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int PROD_W      = 48;
    localparam int DIV_CNT_W   = 6;
    localparam int PC_W        = 5;

    // reset values and fixed floors
    localparam logic [WORD_W-1:0] INIT_WINDOW_RST = 32'd14600;
    localparam logic [SEG_W-1:0]  SEG_SIZE_RST    = 16'd1460;
    localparam logic [WORD_W-1:0] THRESH_FLOOR    = 32'd65535;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_SIZE   = 2'd1;

    // event codes
    typedef enum logic [CMD_W-1:0] {
        CMD_SENT    = 3'd0,
        CMD_ACKED   = 3'd1,
        CMD_FAST    = 3'd2,
        CMD_TIMEOUT = 3'd3,
        CMD_INIT    = 3'd4
    } cmd_t;

    // datapath micro-operations
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_FLT_ADD,
        UOP_FLT_SUB,
        UOP_FLT_CLR,
        UOP_WIN_SEED,
        UOP_THR_SEED,
        UOP_WIN_SS,
        UOP_DIV_START,
        UOP_WIN_CA,
        UOP_THR_HALVE,
        UOP_WIN_FAST,
        UOP_WIN_SEG,
        UOP_WIN_INIT,
        UOP_EMIT
    } uop_t;

    // jump conditions
    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_WIN_ZERO,
        COND_SLOW_START,
        COND_DIV_BUSY
    } cond_t;

    // one control word of the program
    typedef struct packed {
        uop_t             uop;
        cond_t            cond;
        logic [PC_W-1:0]  target;
        logic             last;
    } ctrl_word_t;

    // sequencer to datapath
    typedef struct packed {
        uop_t uop;
        logic load;
    } dp_ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic win_zero;
        logic slow_start;
        logic div_busy;
        logic out_free;
    } dp_status_t;

    // program addresses
    localparam logic [PC_W-1:0] A_SENT      = 5'd0;
    localparam logic [PC_W-1:0] A_ACK       = 5'd1;
    localparam logic [PC_W-1:0] A_ACK_MODE  = 5'd2;
    localparam logic [PC_W-1:0] A_DIV       = 5'd3;
    localparam logic [PC_W-1:0] A_DIV_WAIT  = 5'd4;
    localparam logic [PC_W-1:0] A_CA        = 5'd5;
    localparam logic [PC_W-1:0] A_ACK_ZERO  = 5'd6;
    localparam logic [PC_W-1:0] A_ACK_SEED  = 5'd7;
    localparam logic [PC_W-1:0] A_SS        = 5'd8;
    localparam logic [PC_W-1:0] A_FAST      = 5'd9;
    localparam logic [PC_W-1:0] A_FAST_WIN  = 5'd10;
    localparam logic [PC_W-1:0] A_TMO       = 5'd11;
    localparam logic [PC_W-1:0] A_TMO_WIN   = 5'd12;
    localparam logic [PC_W-1:0] A_TMO_FLT   = 5'd13;
    localparam logic [PC_W-1:0] A_INIT      = 5'd14;
    localparam logic [PC_W-1:0] A_INIT_SEED = 5'd15;
    localparam logic [PC_W-1:0] A_EMIT      = 5'd16;

    function automatic ctrl_word_t mk(uop_t u, cond_t c, logic [PC_W-1:0] t, logic l);
        ctrl_word_t w;
        w.uop    = u;
        w.cond   = c;
        w.target = t;
        w.last   = l;
        return w;
    endfunction

    // microcode read-only program
    function automatic ctrl_word_t ucode(logic [PC_W-1:0] pc);
        ctrl_word_t w;
        unique case (pc)
            A_SENT:      w = mk(UOP_FLT_ADD,   COND_ALWAYS,     A_EMIT,     1'b0);
            A_ACK:       w = mk(UOP_FLT_SUB,   COND_WIN_ZERO,   A_ACK_ZERO, 1'b0);
            A_ACK_MODE:  w = mk(UOP_NOP,       COND_SLOW_START, A_SS,       1'b0);
            A_DIV:       w = mk(UOP_DIV_START, COND_NONE,       A_EMIT,     1'b0);
            A_DIV_WAIT:  w = mk(UOP_NOP,       COND_DIV_BUSY,   A_DIV_WAIT, 1'b0);
            A_CA:        w = mk(UOP_WIN_CA,    COND_ALWAYS,     A_EMIT,     1'b0);
            A_ACK_ZERO:  w = mk(UOP_WIN_SEED,  COND_NONE,       A_EMIT,     1'b0);
            A_ACK_SEED:  w = mk(UOP_THR_SEED,  COND_ALWAYS,     A_EMIT,     1'b0);
            A_SS:        w = mk(UOP_WIN_SS,    COND_ALWAYS,     A_EMIT,     1'b0);
            A_FAST:      w = mk(UOP_THR_HALVE, COND_NONE,       A_EMIT,     1'b0);
            A_FAST_WIN:  w = mk(UOP_WIN_FAST,  COND_ALWAYS,     A_EMIT,     1'b0);
            A_TMO:       w = mk(UOP_THR_HALVE, COND_NONE,       A_EMIT,     1'b0);
            A_TMO_WIN:   w = mk(UOP_WIN_SEG,   COND_NONE,       A_EMIT,     1'b0);
            A_TMO_FLT:   w = mk(UOP_FLT_CLR,   COND_ALWAYS,     A_EMIT,     1'b0);
            A_INIT:      w = mk(UOP_WIN_INIT,  COND_NONE,       A_EMIT,     1'b0);
            A_INIT_SEED: w = mk(UOP_THR_SEED,  COND_ALWAYS,     A_EMIT,     1'b0);
            A_EMIT:      w = mk(UOP_EMIT,      COND_NONE,       A_EMIT,     1'b1);
            default:     w = mk(UOP_NOP,       COND_ALWAYS,     A_EMIT,     1'b0);
        endcase
        return w;
    endfunction

    // entry point of each event
    function automatic logic [PC_W-1:0] entry(logic [CMD_W-1:0] cmd);
        logic [PC_W-1:0] a;
        unique case (cmd)
            CMD_SENT:    a = A_SENT;
            CMD_ACKED:   a = A_ACK;
            CMD_FAST:    a = A_FAST;
            CMD_TIMEOUT: a = A_TMO;
            CMD_INIT:    a = A_INIT;
            default:     a = A_EMIT;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// File: sv/trcw_divider.sv
// ----------------------------------------------------------------------------
// trcw_divider
// Restoring divider, one quotient bit per cycle, for the congestion
// avoidance increment.
// ----------------------------------------------------------------------------
`default_nettype none

module trcw_divider (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [trcw_pkg::PROD_W-1:0]   dividend,
    input  wire logic [trcw_pkg::WORD_W-1:0]   divisor,
    output logic                               busy,
    output logic [trcw_pkg::PROD_W-1:0]        quotient
);

    logic [trcw_pkg::PROD_W-1:0]    quo_reg, quo_next;
    logic [trcw_pkg::WORD_W-1:0]    rem_reg, rem_next;
    logic [trcw_pkg::WORD_W-1:0]    dvs_reg, dvs_next;
    logic [trcw_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic [trcw_pkg::WORD_W+1:0]    trial;

    // trial subtraction of the shifted remainder
    assign trial = {1'b0, rem_reg, quo_reg[trcw_pkg::PROD_W-1]} - {2'b00, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = trcw_pkg::DIV_CNT_W'(trcw_pkg::PROD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[trcw_pkg::WORD_W+1])
            begin
                rem_next = trial[trcw_pkg::WORD_W-1:0];
                quo_next = {quo_reg[trcw_pkg::PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[trcw_pkg::WORD_W-2:0], quo_reg[trcw_pkg::PROD_W-1]};
                quo_next = {quo_reg[trcw_pkg::PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - trcw_pkg::DIV_CNT_W'(1);
            if (cnt_reg == trcw_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: sv/trcw_datapath.sv
// ----------------------------------------------------------------------------
// trcw_datapath
// Window, threshold and flight registers, configuration registers, the
// input latch, the result register and the increment divider.
// ----------------------------------------------------------------------------
`default_nettype none

module trcw_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire trcw_pkg::dp_ctrl_t                ctrl,
    output trcw_pkg::dp_status_t                   status,
    input  wire logic [trcw_pkg::WORD_W-1:0]       in_bytes,
    input  wire logic [trcw_pkg::WORD_W-1:0]       in_peer,
    input  wire logic                              cfg_we,
    input  wire logic [trcw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [trcw_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic [trcw_pkg::OUT_TDATA_W-1:0]       out_data
);

    localparam int W = trcw_pkg::WORD_W;
    localparam int P = trcw_pkg::PROD_W;

    logic [W-1:0]  win_reg, win_next;
    logic [W-1:0]  thr_reg, thr_next;
    logic [W-1:0]  flt_reg, flt_next;
    logic [W-1:0]  iwin_reg, iwin_next;
    logic [trcw_pkg::SEG_W-1:0] seg_reg, seg_next;
    logic [W-1:0]  bytes_reg, peer_reg;
    logic          ov_reg, ov_next;
    logic [trcw_pkg::OUT_TDATA_W-1:0] od_reg, od_next;

    logic [W:0]    flt_sum, win_sum, fast_sum;
    logic [W-1:0]  seg_w, seg2_w, half_w, ack_nz, send_w;
    logic [P-1:0]  prod, inc;
    logic [P:0]    ca_sum;
    logic [W-1:0]  thr_seeded, win_seeded;
    logic          div_busy;
    logic [P-1:0]  quo;
    logic          div_start;

    // operand preparation
    assign seg_w      = W'(seg_reg);
    assign seg2_w     = {seg_w[W-2:0], 1'b0};
    assign half_w     = {1'b0, win_reg[W-1:1]};
    assign ack_nz     = (bytes_reg == '0) ? W'(1) : bytes_reg;
    assign flt_sum    = {1'b0, flt_reg} + {1'b0, bytes_reg};
    assign win_sum    = {1'b0, win_reg} + {1'b0, bytes_reg};
    assign fast_sum   = {1'b0, thr_reg} + {1'b0, seg2_w} + {1'b0, seg_w};
    assign thr_seeded = (thr_reg != '0) ? thr_reg
                      : ((win_reg > trcw_pkg::THRESH_FLOOR) ? win_reg : trcw_pkg::THRESH_FLOOR);
    assign win_seeded = (bytes_reg > seg_w) ? bytes_reg : seg_w;
    assign send_w     = ((win_reg == '0) || (peer_reg < win_reg)) ? peer_reg : win_reg;

    // multiplier feeds the divider load register
    assign prod      = P'(seg_reg) * P'(ack_nz);
    assign div_start = (ctrl.uop == trcw_pkg::UOP_DIV_START);

    // congestion avoidance increment, at least one
    assign inc    = (quo == '0) ? P'(1) : quo;
    assign ca_sum = {1'b0, P'(win_reg)} + {1'b0, inc};

    trcw_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod),
        .divisor  (win_reg),
        .busy     (div_busy),
        .quotient (quo)
    );

    // micro-operation execution
    always_comb
    begin
        win_next = win_reg;
        thr_next = thr_reg;
        flt_next = flt_reg;
        ov_next  = ov_reg & ~out_ready;
        od_next  = od_reg;
        case (ctrl.uop)
            trcw_pkg::UOP_FLT_ADD:   flt_next = flt_sum[W] ? '1 : flt_sum[W-1:0];
            trcw_pkg::UOP_FLT_SUB:   flt_next = (bytes_reg > flt_reg) ? '0 : flt_reg - bytes_reg;
            trcw_pkg::UOP_FLT_CLR:   flt_next = '0;
            trcw_pkg::UOP_WIN_SEED:  win_next = win_seeded;
            trcw_pkg::UOP_THR_SEED:  thr_next = thr_seeded;
            trcw_pkg::UOP_WIN_SS:    win_next = win_sum[W] ? '1 : win_sum[W-1:0];
            trcw_pkg::UOP_WIN_CA:    win_next = (ca_sum[P:W] != '0) ? '1 : ca_sum[W-1:0];
            trcw_pkg::UOP_THR_HALVE: thr_next = (half_w > seg2_w) ? half_w : seg2_w;
            trcw_pkg::UOP_WIN_FAST:  win_next = fast_sum[W] ? '1 : fast_sum[W-1:0];
            trcw_pkg::UOP_WIN_SEG:   win_next = seg_w;
            trcw_pkg::UOP_WIN_INIT:  win_next = iwin_reg;
            trcw_pkg::UOP_EMIT:
            begin
                ov_next = 1'b1;
                od_next = {send_w, flt_reg, thr_reg, win_reg};
            end
            default: ;
        endcase
    end

    // configuration writes
    always_comb
    begin
        iwin_next = iwin_reg;
        seg_next  = seg_reg;
        if (cfg_we && (cfg_index == trcw_pkg::REG_INITIAL_WINDOW))
        begin
            iwin_next = cfg_data;
        end
        if (cfg_we && (cfg_index == trcw_pkg::REG_SEGMENT_SIZE))
        begin
            seg_next = cfg_data[trcw_pkg::SEG_W-1:0];
        end
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= '0;
            thr_reg  <= '0;
            flt_reg  <= '0;
            iwin_reg <= trcw_pkg::INIT_WINDOW_RST;
            seg_reg  <= trcw_pkg::SEG_SIZE_RST;
            ov_reg   <= 1'b0;
        end
        else
        begin
            win_reg  <= win_next;
            thr_reg  <= thr_next;
            flt_reg  <= flt_next;
            iwin_reg <= iwin_next;
            seg_reg  <= seg_next;
            ov_reg   <= ov_next;
        end
    end

    // input latch and result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            bytes_reg <= in_bytes;
            peer_reg  <= in_peer;
        end
        od_reg <= od_next;
    end

    assign status.win_zero   = (win_reg == '0);
    assign status.slow_start = (win_reg < thr_reg);
    assign status.div_busy   = div_busy;
    assign status.out_free   = ~ov_reg | out_ready;

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule

`default_nettype wire

// File: sv/trcw_sequencer.sv
// ----------------------------------------------------------------------------
// trcw_sequencer
// Step counter over the microcode program with conditional jumps and the
// event dispatch.
// ----------------------------------------------------------------------------
`default_nettype none

module trcw_sequencer (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic [trcw_pkg::CMD_W-1:0]    in_cmd,
    output logic                               in_ready,
    input  wire trcw_pkg::dp_status_t          status,
    output trcw_pkg::dp_ctrl_t                 ctrl
);

    logic [trcw_pkg::PC_W-1:0] pc_reg, pc_next;
    logic                      busy_reg, busy_next;
    trcw_pkg::ctrl_word_t      cw;
    logic                      accept, stall, taken, run;

    // fetch and hold-off on a full result register
    assign cw     = trcw_pkg::ucode(pc_reg);
    assign accept = in_valid & ~busy_reg;
    assign stall  = (cw.uop == trcw_pkg::UOP_EMIT) & ~status.out_free;
    assign run    = busy_reg & ~stall;

    // jump condition
    always_comb
    begin
        unique case (cw.cond)
            trcw_pkg::COND_NONE:       taken = 1'b0;
            trcw_pkg::COND_ALWAYS:     taken = 1'b1;
            trcw_pkg::COND_WIN_ZERO:   taken = status.win_zero;
            trcw_pkg::COND_SLOW_START: taken = status.slow_start;
            trcw_pkg::COND_DIV_BUSY:   taken = status.div_busy;
            default:                   taken = 1'b0;
        endcase
    end

    // next step
    always_comb
    begin
        pc_next   = pc_reg;
        busy_next = busy_reg;
        if (accept)
        begin
            pc_next   = trcw_pkg::entry(in_cmd);
            busy_next = 1'b1;
        end
        else if (run)
        begin
            pc_next = taken ? cw.target : pc_reg + trcw_pkg::PC_W'(1);
            if (cw.last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= trcw_pkg::A_EMIT;
            busy_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            busy_reg <= busy_next;
        end
    end

    assign in_ready  = ~busy_reg;
    assign ctrl.uop  = run ? cw.uop : trcw_pkg::UOP_NOP;
    assign ctrl.load = accept;

endmodule

`default_nettype wire

// File: sv/tcp_reno_congestion_window.sv
// ----------------------------------------------------------------------------
// tcp_reno_congestion_window
// Reno congestion window, slow start threshold and flight tracker for one
// connection, run by a microcoded sequencer over a small datapath.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         event: cmd, byte_count, peer_window
//  m_axis    out        window, threshold, bytes in flight, send window
//  cfg       in         write: 0 initial_window, 1 segment_size
//
//  one item at a time; a congestion avoidance ack is the slowest event, set
//  by the 48-step one-bit-per-cycle divider of the increment.
//  the next item can be taken once the result is written to the
//  result register, even while that result waits on m_tready.
//  reset clears window, threshold and flight to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tcp_reno_congestion_window (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // cmd[2:0], byte_count[34:3], peer_window[66:35], zero fill
    input  wire logic [trcw_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // congestion_window[31:0], slow_start_threshold[63:32],
    // bytes_outstanding[95:64], send_window[127:96]
    output logic [trcw_pkg::OUT_TDATA_W-1:0]       m_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic                              cfg_we,
    input  wire logic [trcw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [trcw_pkg::CFG_DATA_W-1:0]   cfg_data
);

    trcw_pkg::dp_ctrl_t   ctrl;
    trcw_pkg::dp_status_t status;

    trcw_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_cmd   (s_tdata[2:0]),
        .in_ready (s_tready),
        .status   (status),
        .ctrl     (ctrl)
    );

    trcw_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .status    (status),
        .in_bytes  (s_tdata[34:3]),
        .in_peer   (s_tdata[66:35]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

// File: sv/trcw_checker.sv
// ----------------------------------------------------------------------------
// trcw_checker
// Port-level checks of the congestion window tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module trcw_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic [trcw_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready
);

    // one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while another is in work");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // send window never exceeds a nonzero congestion window
    a_send_win: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[31:0] != 32'd0) |-> m_tdata[127:96] <= m_tdata[31:0])
        else $error("send window above congestion window");

endmodule

bind tcp_reno_congestion_window trcw_checker u_trcw_checker (.*);

`default_nettype wire
